[sv/eegcd_pkg.sv]
`default_nettype none

package eegcd_pkg;

    // width of the payload fields on the ports
    localparam int FIELD_BITS = 64;

    // working word width of the remainder chain and coefficients (8 to 64)
    localparam int WORD_BITS = 64;

    // divider step counter
    localparam int CNT_BITS = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] value_a;
        logic signed [FIELD_BITS-1:0] value_b;
    } t_in_beat;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] gcd_value;
        logic signed [FIELD_BITS-1:0] coeff_a;
        logic signed [FIELD_BITS-1:0] coeff_b;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE
    } t_state;

endpackage

`default_nettype wire

[sv/extended_euclid_gcd_unit.sv]
`default_nettype none
// Extended Euclid unit: takes a pair (value_a, value_b) on the input channel
// (i_valid / o_ready, payload i_data) and returns one beat (gcd_value, coeff_a,
// coeff_b) on the output channel (o_valid / i_ready, payload o_data), with
// value_a*coeff_a + value_b*coeff_b = gcd_value modulo 2^WORD_BITS.
// Quotients truncate toward zero, so gcd_value may be negative.
// Each Euclid iteration runs one restoring shift-subtract divider, one
// quotient bit a cycle; the Bezout products q*s and q*t are built
// alongside, in the same cycles as the quotient bits, by shift-and-add.
// Each iteration goes through ST_CHECK, ST_DIV and ST_UPDATE. There are no
// iterations when value_b is 0, and at most about 92 for 64-bit words. One
// pair is in work at a time; o_ready is high only while the unit is idle.
// The result sits in an output register, so a new pair is taken while the
// previous result still waits; if the receiver stalls, the next result waits
// in the sequencer until the output register is free.
// Reset (synchronous, active low) empties the output register and returns
// the sequencer to idle.
module extended_euclid_gcd_unit
    import eegcd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_beat  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_beat      o_data
);

    localparam t_cnt CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    t_state    r_state, n_state;
    t_word     r_prev_r, n_prev_r, r_cur_r, n_cur_r;
    t_word     r_prev_s, n_prev_s, r_cur_s, n_cur_s;
    t_word     r_prev_t, n_prev_t, r_cur_t, n_cur_t;
    t_word     r_num, n_num, r_den, n_den, r_rem, n_rem;
    t_word     r_acc_s, n_acc_s, r_acc_t, n_acc_t;
    t_cnt      r_cnt, n_cnt;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;

    // divider step signals
    t_word     w_partial;
    t_word     w_diff;
    logic      w_qbit;
    logic      w_prev_neg;
    logic      w_cur_neg;
    logic      w_out_free;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prev_r <= n_prev_r;
        r_cur_r  <= n_cur_r;
        r_prev_s <= n_prev_s;
        r_cur_s  <= n_cur_s;
        r_prev_t <= n_prev_t;
        r_cur_t  <= n_cur_t;
        r_num    <= n_num;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_acc_s  <= n_acc_s;
        r_acc_t  <= n_acc_t;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

    // one restoring divider step: shift in next dividend bit, trial subtract
    always_comb begin
        w_partial = {r_rem[WORD_BITS-2:0], r_num[WORD_BITS-1]};
        w_diff    = w_partial - r_den;
        w_qbit    = (w_partial >= r_den);
    end

    assign w_prev_neg = r_prev_r[WORD_BITS-1];
    assign w_cur_neg  = r_cur_r[WORD_BITS-1];
    assign w_out_free = !r_out_valid || i_ready;

    // sequencer and datapath next values
    always_comb begin
        n_state     = r_state;
        n_prev_r    = r_prev_r;
        n_cur_r     = r_cur_r;
        n_prev_s    = r_prev_s;
        n_cur_s     = r_cur_s;
        n_prev_t    = r_prev_t;
        n_cur_t     = r_cur_t;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_acc_s     = r_acc_s;
        n_acc_t     = r_acc_t;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_ready     = (r_state == ST_IDLE);

        case (r_state)
            // take a new pair
            ST_IDLE: begin
                if (i_valid) begin
                    n_prev_r = i_data.value_a[WORD_BITS-1:0];
                    n_cur_r  = i_data.value_b[WORD_BITS-1:0];
                    n_prev_s = WORD_BITS'(1);
                    n_cur_s  = '0;
                    n_prev_t = '0;
                    n_cur_t  = WORD_BITS'(1);
                    n_state  = ST_CHECK;
                end
            end
            // chain ends on a zero remainder, else start the next division
            ST_CHECK: begin
                if (r_cur_r == '0) begin
                    if (w_out_free) begin
                        n_out.gcd_value = FIELD_BITS'($signed(r_prev_r));
                        n_out.coeff_a   = FIELD_BITS'($signed(r_prev_s));
                        n_out.coeff_b   = FIELD_BITS'($signed(r_prev_t));
                        n_out_valid     = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else begin
                    n_num   = w_prev_neg ? t_word'('0 - r_prev_r) : r_prev_r;
                    n_den   = w_cur_neg  ? t_word'('0 - r_cur_r)  : r_cur_r;
                    n_rem   = '0;
                    n_acc_s = '0;
                    n_acc_t = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            // one quotient bit a cycle, products q*s and q*t by shift-and-add
            ST_DIV: begin
                n_rem   = w_qbit ? w_diff : w_partial;
                n_num   = {r_num[WORD_BITS-2:0], 1'b0};
                n_acc_s = {r_acc_s[WORD_BITS-2:0], 1'b0} + (w_qbit ? r_cur_s : '0);
                n_acc_t = {r_acc_t[WORD_BITS-2:0], 1'b0} + (w_qbit ? r_cur_t : '0);
                n_cnt   = r_cnt + t_cnt'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_UPDATE;
                end
            end
            // apply signs and advance the remainder and coefficient pairs
            ST_UPDATE: begin
                n_prev_r = r_cur_r;
                n_cur_r  = w_prev_neg ? t_word'('0 - r_rem) : r_rem;
                n_prev_s = r_cur_s;
                n_prev_t = r_cur_t;
                if (w_prev_neg ^ w_cur_neg) begin
                    n_cur_s = r_prev_s + r_acc_s;
                    n_cur_t = r_prev_t + r_acc_t;
                end else begin
                    n_cur_s = r_prev_s - r_acc_s;
                    n_cur_t = r_prev_t - r_acc_t;
                end
                n_state = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire
